>>> hw/rtl/sipd_pkg.sv
package sipd_pkg;

	localparam int DURATION_BITS_DEF = 15;
	localparam int MARGIN_BITS       = 15;
	localparam int CMD_BITS          = 7;
	localparam int ADDR_BITS         = 13;
	localparam int COUNT_BITS        = 5;
	localparam int TOTAL_BITS        = COUNT_BITS + 1;
	localparam int COUNT_MAX         = (1 << COUNT_BITS) - 1;
	localparam int REPEAT_WORDS      = 2;
	localparam int VARIANT_BITS      = 2;
	localparam int CFG_INDEX_BITS    = 3;
	localparam int NUM_TIMINGS       = 4;
	localparam int QUEUE_DEPTH       = 2;

	// slots of the timing register bank
	localparam int TIM_LEADER = 0;
	localparam int TIM_REPEAT = 1;
	localparam int TIM_ZERO   = 2;
	localparam int TIM_ONE    = 3;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_FRAME_VARIANT = 3'd0,
		REG_INVERT_LEVELS = 3'd1,
		REG_TOLERANCE     = 3'd2,
		REG_LEADER_TIMING = 3'd3,
		REG_REPEAT_TIMING = 3'd4,
		REG_ZERO_TIMING   = 3'd5,
		REG_ONE_TIMING    = 3'd6
	} reg_index_t;

	typedef enum logic [VARIANT_BITS-1:0] {
		VAR_12BIT = 2'd0,
		VAR_15BIT = 2'd1,
		VAR_20BIT = 2'd2
	} variant_t;

	typedef enum logic [1:0] {
		ST_DATA    = 2'd0,
		ST_REPEAT  = 2'd1,
		ST_BAD_LEN = 2'd2,
		ST_HDR_ERR = 2'd3
	} status_t;

	// one classified pulse word
	typedef struct packed {
		logic leader_hit;
		logic repeat_hit;
		logic bit_val;
		logic last;
	} word_class_t;

	typedef struct packed {
		status_t              status;
		logic [ADDR_BITS-1:0] address;
		logic [CMD_BITS-1:0]  command;
		logic                 is_repeat;
	} result_t;

	// total words of a data frame, zero where the variant has none
	function automatic logic [TOTAL_BITS-1:0] frame_words(logic [VARIANT_BITS-1:0] v);
		case (v)
			VAR_12BIT: return TOTAL_BITS'(CMD_BITS + 5 + 1);
			VAR_15BIT: return TOTAL_BITS'(CMD_BITS + 8 + 1);
			VAR_20BIT: return TOTAL_BITS'(CMD_BITS + 13 + 1);
			default:   return '0;
		endcase
	endfunction

	function automatic logic [ADDR_BITS-1:0] addr_mask(logic [VARIANT_BITS-1:0] v);
		case (v)
			VAR_12BIT: return ADDR_BITS'((1 << 5) - 1);
			VAR_15BIT: return ADDR_BITS'((1 << 8) - 1);
			VAR_20BIT: return ADDR_BITS'((1 << 13) - 1);
			default:   return '0;
		endcase
	endfunction

endpackage

>>> hw/rtl/sony_ir_pulse_decoder_top.sv
// ir pulse decoder: classifies pulse words and assembles frames
// throughput: one pulse word per cycle, as long as results are popped
// path: the last word of a frame is registered in the classify stage, then in the word queue;
// the frame assembler then writes the result into a 2-deep result queue that drives the result ports
// reset: arst_n clears the registers, the frame state, saved address/command and both queues
module sony_ir_pulse_decoder_top import sipd_pkg::*; #(
	parameter int DURATION_BITS = DURATION_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic                       first_level,
	input  logic [DURATION_BITS-1:0]   first_ticks,
	input  logic                       second_level,
	input  logic [DURATION_BITS-1:0]   second_ticks,
	input  logic                       last_word,
	output logic                       empty,
	input  logic                       pop,
	output logic [1:0]                 status,
	output logic [ADDR_BITS-1:0]       address,
	output logic [CMD_BITS-1:0]        command,
	output logic                       is_repeat,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [2*DURATION_BITS-1:0] cfg_data
);

	localparam int TW = 2 * DURATION_BITS;

	logic [VARIANT_BITS-1:0]         variant_q;
	logic                            invert_q;
	logic [MARGIN_BITS-1:0]          margin_q;
	logic [NUM_TIMINGS-1:0][TW-1:0]  timing_q;

	logic        word_valid;
	word_class_t word_s1;
	logic        word_full;
	logic        mid_valid;
	word_class_t mid_word;
	logic        mid_pop;
	logic        out_full;
	logic        res_valid;
	result_t     res;
	result_t     out_word;
	logic        out_valid;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q <= '0;
			invert_q  <= 1'b0;
			margin_q  <= '0;
			timing_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FRAME_VARIANT: variant_q <= cfg_data[VARIANT_BITS-1:0];
				REG_INVERT_LEVELS: invert_q <= cfg_data[0];
				REG_TOLERANCE:     margin_q <= cfg_data[MARGIN_BITS-1:0];
				REG_LEADER_TIMING: timing_q[TIM_LEADER] <= cfg_data;
				REG_REPEAT_TIMING: timing_q[TIM_REPEAT] <= cfg_data;
				REG_ZERO_TIMING:   timing_q[TIM_ZERO] <= cfg_data;
				REG_ONE_TIMING:    timing_q[TIM_ONE] <= cfg_data;
				default: ;
			endcase
		end
	end

	sipd_front #(
		.DURATION_BITS(DURATION_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.first_level  (first_level),
		.first_ticks  (first_ticks),
		.second_level (second_level),
		.second_ticks (second_ticks),
		.last_word    (last_word),
		.invert_levels(invert_q),
		.tolerance    (margin_q),
		.timings      (timing_q),
		.word_valid   (word_valid),
		.word         (word_s1),
		.word_ready   (!word_full)
	);

	sipd_fifo #(
		.WIDTH($bits(word_class_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_word_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (word_valid),
		.wdata (word_s1),
		.full  (word_full),
		.pop   (mid_pop),
		.rdata (mid_word),
		.valid (mid_valid)
	);

	sipd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.word_valid   (mid_valid),
		.word         (mid_word),
		.word_pop     (mid_pop),
		.frame_variant(variant_q),
		.out_full     (out_full),
		.res_valid    (res_valid),
		.res          (res)
	);

	sipd_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_valid),
		.wdata (res),
		.full  (out_full),
		.pop   (pop),
		.rdata (out_word),
		.valid (out_valid)
	);

	assign empty     = !out_valid;
	assign status    = out_word.status;
	assign address   = out_word.address;
	assign command   = out_word.command;
	assign is_repeat = out_word.is_repeat;

`ifndef SYNTHESIS
	a_repeat_flag: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (is_repeat == (status == ST_REPEAT)))
		else $error("is_repeat disagrees with status");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (status == ST_BAD_LEN || status == ST_HDR_ERR)) |->
		(address == '0 && command == '0))
		else $error("error result carries address or command");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !out_full)
		else $error("result produced into a full result queue");

	a_pop_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> mid_valid)
		else $error("frame assembler consumed a missing word");
`endif

endmodule

>>> hw/rtl/sipd_fifo.sv
module sipd_fifo import sipd_pkg::*; #(
	parameter int WIDTH = 4,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             valid
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign valid   = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop  = pop && valid;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/sipd_front.sv
module sipd_front import sipd_pkg::*; #(
	parameter int DURATION_BITS = DURATION_BITS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          push,
	output logic                                          full,
	input  logic                                          first_level,
	input  logic [DURATION_BITS-1:0]                      first_ticks,
	input  logic                                          second_level,
	input  logic [DURATION_BITS-1:0]                      second_ticks,
	input  logic                                          last_word,
	input  logic                                          invert_levels,
	input  logic [MARGIN_BITS-1:0]                        tolerance,
	input  logic [NUM_TIMINGS-1:0][2*DURATION_BITS-1:0]   timings,
	output logic                                          word_valid,
	output word_class_t                                   word,
	input  logic                                          word_ready
);

	localparam int TW = 2 * DURATION_BITS;
	localparam int CW = ((DURATION_BITS > MARGIN_BITS) ? DURATION_BITS : MARGIN_BITS) + 1;

	logic        valid_s1;
	word_class_t word_s1;
	word_class_t cls;

	// strict open window, never matches when the margin exceeds the target
	function automatic logic in_window(logic [DURATION_BITS-1:0] raw,
			logic [DURATION_BITS-1:0] target, logic [MARGIN_BITS-1:0] m);
		logic [CW-1:0] r_e;
		logic [CW-1:0] t_e;
		logic [CW-1:0] m_e;
		r_e = CW'(raw);
		t_e = CW'(target);
		m_e = CW'(m);
		return (m_e <= t_e) && (r_e > (t_e - m_e)) && (r_e < (t_e + m_e));
	endfunction

	function automatic logic word_match(logic [TW-1:0] timing);
		return (first_level == invert_levels) && (second_level != invert_levels) &&
			in_window(first_ticks, timing[TW-1:DURATION_BITS], tolerance) &&
			in_window(second_ticks, timing[DURATION_BITS-1:0], tolerance);
	endfunction

	always_comb begin
		cls.leader_hit = word_match(timings[TIM_LEADER]);
		cls.repeat_hit = word_match(timings[TIM_REPEAT]);
		// a zero match wins over a one match
		cls.bit_val    = !word_match(timings[TIM_ZERO]) && word_match(timings[TIM_ONE]);
		cls.last       = last_word;
	end

	assign full       = valid_s1 && !word_ready;
	assign word_valid = valid_s1;
	assign word       = word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!full) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			word_s1 <= cls;
		end
	end

endmodule

>>> hw/rtl/sipd_back.sv
module sipd_back import sipd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    word_valid,
	input  word_class_t             word,
	output logic                    word_pop,
	input  logic [VARIANT_BITS-1:0] frame_variant,
	input  logic                    out_full,
	output logic                    res_valid,
	output result_t                 res
);

	logic [COUNT_BITS-1:0] count_q;
	logic                  leader_q;
	logic                  repeat_q;
	logic [CMD_BITS-1:0]   cmd_q;
	logic [ADDR_BITS-1:0]  addr_q;
	logic [ADDR_BITS-1:0]  saved_addr_q;
	logic [CMD_BITS-1:0]   saved_cmd_q;

	logic [COUNT_BITS-1:0] count_nxt;
	logic                  leader_nxt;
	logic                  repeat_nxt;
	logic [CMD_BITS-1:0]   cmd_nxt;
	logic [ADDR_BITS-1:0]  addr_nxt;
	logic [TOTAL_BITS-1:0] total;
	logic [TOTAL_BITS-1:0] data_words;
	logic                  save_en;

	assign word_pop  = word_valid && !out_full;
	assign res_valid = word_pop && word.last;

	always_comb begin
		leader_nxt = leader_q;
		repeat_nxt = repeat_q;
		cmd_nxt    = cmd_q;
		addr_nxt   = addr_q;
		if (count_q == '0) begin
			leader_nxt = word.leader_hit;
			repeat_nxt = word.repeat_hit;
		end
		// lsb first: command bits, then address bits; later words only count
		for (int i = 0; i < CMD_BITS; i++) begin
			if (count_q == COUNT_BITS'(i + 1)) begin
				cmd_nxt[i] = cmd_q[i] | word.bit_val;
			end
		end
		for (int i = 0; i < ADDR_BITS; i++) begin
			if (count_q == COUNT_BITS'(CMD_BITS + 1 + i)) begin
				addr_nxt[i] = addr_q[i] | word.bit_val;
			end
		end
		count_nxt = (count_q == COUNT_BITS'(COUNT_MAX)) ? count_q : count_q + 1'b1;
	end

	always_comb begin
		total         = TOTAL_BITS'(count_q) + 1'b1;
		data_words    = frame_words(frame_variant);
		res.status    = ST_BAD_LEN;
		res.address   = '0;
		res.command   = '0;
		res.is_repeat = 1'b0;
		save_en       = 1'b0;
		if ((data_words != '0) && (total == data_words)) begin
			if (leader_nxt) begin
				res.status  = ST_DATA;
				res.address = addr_nxt & addr_mask(frame_variant);
				res.command = cmd_nxt;
				save_en     = 1'b1;
			end else begin
				res.status = ST_HDR_ERR;
			end
		end else if (total == TOTAL_BITS'(REPEAT_WORDS)) begin
			if (repeat_nxt) begin
				res.status    = ST_REPEAT;
				res.address   = saved_addr_q;
				res.command   = saved_cmd_q;
				res.is_repeat = 1'b1;
			end else begin
				res.status = ST_HDR_ERR;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			leader_q     <= 1'b0;
			repeat_q     <= 1'b0;
			cmd_q        <= '0;
			addr_q       <= '0;
			saved_addr_q <= '0;
			saved_cmd_q  <= '0;
		end else if (word_pop) begin
			if (word.last) begin
				count_q  <= '0;
				leader_q <= 1'b0;
				repeat_q <= 1'b0;
				cmd_q    <= '0;
				addr_q   <= '0;
				if (save_en) begin
					saved_addr_q <= res.address;
					saved_cmd_q  <= res.command;
				end
			end else begin
				count_q  <= count_nxt;
				leader_q <= leader_nxt;
				repeat_q <= repeat_nxt;
				cmd_q    <= cmd_nxt;
				addr_q   <= addr_nxt;
			end
		end
	end

endmodule
